/* hdl/cau_pkg.sv */
// shared types, widths and helper functions for the complex arithmetic unit
// no dependencies; used by every module of the block
`default_nettype none

package cau_pkg;

   localparam int DATA_W    = 16;
   localparam int FRAC_BITS = 8;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int DIRECT_W  = SUM_W - FRAC_BITS;
   localparam int QUO_W     = DATA_W + 1;
   localparam int MAG_W     = PROD_W;
   localparam int NUM_W     = MAG_W + FRAC_BITS;
   localparam int DEN_W     = PROD_W;
   localparam int DIV_W     = DEN_W + QUO_W - 1;
   localparam int CMP_W     = DEN_W + QUO_W;

   localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   // output of the product and sum stages
   typedef struct packed {
      logic                       valid;
      logic                       is_div;
      logic signed [DIRECT_W-1:0] direct_re;
      logic signed [DIRECT_W-1:0] direct_im;
      logic signed [SUM_W-1:0]    num_re;
      logic signed [SUM_W-1:0]    num_im;
      logic [DEN_W-1:0]           den;
   } mult_pipe_type;

   // one stage of the divider pipeline, side data rides along
   typedef struct packed {
      logic                       valid;
      logic                       is_div;
      logic                       dz;
      logic                       neg_re;
      logic                       neg_im;
      logic                       big_re;
      logic                       big_im;
      logic signed [DIRECT_W-1:0] direct_re;
      logic signed [DIRECT_W-1:0] direct_im;
      logic [NUM_W-1:0]           r_re;
      logic [NUM_W-1:0]           r_im;
      logic [QUO_W-1:0]           q_re;
      logic [QUO_W-1:0]           q_im;
      logic [DIV_W-1:0]           d;
   } div_pipe_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     ovf;
   } sat_type;

   function automatic sat_type sat_direct(input logic signed [DIRECT_W-1:0] v);
      sat_type s;
      if (v > DIRECT_W'(Q_MAX)) begin
         s.val = Q_MAX;
         s.ovf = 1'b1;
      end else if (v < DIRECT_W'(Q_MIN)) begin
         s.val = Q_MIN;
         s.ovf = 1'b1;
      end else begin
         s.val = v[DATA_W-1:0];
         s.ovf = 1'b0;
      end
      return s;
   endfunction

   // sign and magnitude quotient back to saturated two's complement
   function automatic sat_type sat_quot(input logic neg, input logic big,
                                        input logic [QUO_W-1:0] q);
      sat_type s;
      if (neg) begin
         if (big || q > QUO_W'({1'b0, Q_MIN}) ) begin
            s.val = Q_MIN;
            s.ovf = 1'b1;
         end else begin
            s.val = DATA_W'(-q);
            s.ovf = 1'b0;
         end
      end else begin
         if (big || q > QUO_W'({1'b0, Q_MAX})) begin
            s.val = Q_MAX;
            s.ovf = 1'b1;
         end else begin
            s.val = q[DATA_W-1:0];
            s.ovf = 1'b0;
         end
      end
      return s;
   endfunction

endpackage

`default_nettype wire

/* hdl/cau_mult.sv */
// product stage and sum stage: six 16x16 products, then cross sums and |b|^2
// depends on cau_pkg
`default_nettype none

module cau_mult (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [1:0]                    mode,
   input  wire logic signed [cau_pkg::DATA_W-1:0] a_real,
   input  wire logic signed [cau_pkg::DATA_W-1:0] a_imag,
   input  wire logic signed [cau_pkg::DATA_W-1:0] b_real,
   input  wire logic signed [cau_pkg::DATA_W-1:0] b_imag,
   output cau_pkg::mult_pipe_type             mult_out
);

   logic                                  valid_s1_ff;
   cau_pkg::mode_type                     mode_s1_ff;
   logic signed [cau_pkg::PROD_W-1:0]     p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [cau_pkg::PROD_W-1:0]     p_br2_ff, p_bi2_ff;
   logic signed [cau_pkg::DATA_W:0]       simple_re_ff, simple_im_ff;
   logic signed [cau_pkg::DATA_W:0]       simple_re_in, simple_im_in;

   cau_pkg::mult_pipe_type                mult_ff, mult_in;
   logic signed [cau_pkg::SUM_W-1:0]      mul_re, mul_im;

   always_comb begin
      if (cau_pkg::mode_type'(mode) == cau_pkg::MODE_SUB) begin
         simple_re_in = (cau_pkg::DATA_W+1)'(a_real) - (cau_pkg::DATA_W+1)'(b_real);
         simple_im_in = (cau_pkg::DATA_W+1)'(a_imag) - (cau_pkg::DATA_W+1)'(b_imag);
      end else begin
         simple_re_in = (cau_pkg::DATA_W+1)'(a_real) + (cau_pkg::DATA_W+1)'(b_real);
         simple_im_in = (cau_pkg::DATA_W+1)'(a_imag) + (cau_pkg::DATA_W+1)'(b_imag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
      end else if (en) begin
         valid_s1_ff  <= in_valid;
         mode_s1_ff   <= cau_pkg::mode_type'(mode);
         p_rr_ff      <= a_real * b_real;
         p_ii_ff      <= a_imag * b_imag;
         p_ri_ff      <= a_real * b_imag;
         p_ir_ff      <= a_imag * b_real;
         p_br2_ff     <= b_real * b_real;
         p_bi2_ff     <= b_imag * b_imag;
         simple_re_ff <= simple_re_in;
         simple_im_ff <= simple_im_in;
      end
   end

   always_comb begin
      mul_re = cau_pkg::SUM_W'(p_rr_ff) - cau_pkg::SUM_W'(p_ii_ff);
      mul_im = cau_pkg::SUM_W'(p_ri_ff) + cau_pkg::SUM_W'(p_ir_ff);

      mult_in.valid  = valid_s1_ff;
      mult_in.is_div = (mode_s1_ff == cau_pkg::MODE_DIV);
      // multiply drops the fraction bits with a floor shift
      if (mode_s1_ff == cau_pkg::MODE_MUL) begin
         mult_in.direct_re = mul_re[cau_pkg::SUM_W-1:cau_pkg::FRAC_BITS];
         mult_in.direct_im = mul_im[cau_pkg::SUM_W-1:cau_pkg::FRAC_BITS];
      end else begin
         mult_in.direct_re = cau_pkg::DIRECT_W'(simple_re_ff);
         mult_in.direct_im = cau_pkg::DIRECT_W'(simple_im_ff);
      end
      mult_in.num_re = cau_pkg::SUM_W'(p_rr_ff) + cau_pkg::SUM_W'(p_ii_ff);
      mult_in.num_im = cau_pkg::SUM_W'(p_ir_ff) - cau_pkg::SUM_W'(p_ri_ff);
      // both squares are non-negative and below 2^30 + 1
      mult_in.den    = cau_pkg::DEN_W'(p_br2_ff) + cau_pkg::DEN_W'(p_bi2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff.valid <= 1'b0;
      end else if (en) begin
         mult_ff <= mult_in;
      end
   end

   assign mult_out = mult_ff;

endmodule

`default_nettype wire

/* hdl/cau_div_step.sv */
// one restoring divide step for real and imaginary quotients, shared divisor
// depends on cau_pkg
`default_nettype none

module cau_div_step (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire cau_pkg::div_pipe_type up_pipe,
   output cau_pkg::div_pipe_type dn_pipe
);

   cau_pkg::div_pipe_type pipe_ff, pipe_in;
   logic                  ge_re, ge_im;
   logic [cau_pkg::DIV_W-1:0] diff_re, diff_im;

   always_comb begin
      ge_re   = cau_pkg::DIV_W'(up_pipe.r_re) >= up_pipe.d;
      ge_im   = cau_pkg::DIV_W'(up_pipe.r_im) >= up_pipe.d;
      diff_re = cau_pkg::DIV_W'(up_pipe.r_re) - up_pipe.d;
      diff_im = cau_pkg::DIV_W'(up_pipe.r_im) - up_pipe.d;

      pipe_in      = up_pipe;
      pipe_in.r_re = ge_re ? diff_re[cau_pkg::NUM_W-1:0] : up_pipe.r_re;
      pipe_in.r_im = ge_im ? diff_im[cau_pkg::NUM_W-1:0] : up_pipe.r_im;
      pipe_in.q_re = {up_pipe.q_re[cau_pkg::QUO_W-2:0], ge_re};
      pipe_in.q_im = {up_pipe.q_im[cau_pkg::QUO_W-2:0], ge_im};
      pipe_in.d    = up_pipe.d >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff.valid <= 1'b0;
      end else if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign dn_pipe = pipe_ff;

endmodule

`default_nettype wire

/* hdl/complex_arith_unit_top.sv */
// top level of the complex arithmetic unit: product stages, divide setup,
// divider step chain and saturating output register; depends on cau_pkg,
// cau_mult and cau_div_step
//
// usage:
//   req channel carries mode and the two complex operands a and b (Q8.8),
//   rsp channel returns res_real, res_imag (Q8.8, saturated), overflow and
//   div_zero, one item out for every item in, in order.
//   an item passes 21 register stages: two product/sum stages, one divide
//   setup stage, 17 restoring divide steps (one quotient bit each) and the
//   output register, which drives rsp_valid.
//   all modes take the same path.
//   throughput is one item per cycle while the receiver keeps up.
//   when rsp_valid is high and rsp_ready is low the whole pipeline holds
//   and req_ready drops; nothing is lost or repeated. req_ready stays high
//   while the output register is empty, even if earlier stages are full.
//   synchronous reset empties every stage; payload registers keep garbage.
`default_nettype none

module complex_arith_unit_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_mode,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_a_real,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_a_imag,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_b_real,
   input  wire logic signed [cau_pkg::DATA_W-1:0] req_b_imag,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [cau_pkg::DATA_W-1:0]      rsp_res_real,
   output logic signed [cau_pkg::DATA_W-1:0]      rsp_res_imag,
   output logic                                   rsp_overflow,
   output logic                                   rsp_div_zero
);

   logic                      adv;
   cau_pkg::mult_pipe_type    mult_out;
   cau_pkg::div_pipe_type     prep_ff, prep_in;
   cau_pkg::div_pipe_type     stage_pipe [cau_pkg::QUO_W+1];
   cau_pkg::div_pipe_type     last;

   logic                      neg_re, neg_im;
   logic [cau_pkg::SUM_W-1:0] abs_re, abs_im;
   logic [cau_pkg::NUM_W-1:0] scaled_re, scaled_im;
   logic [cau_pkg::CMP_W-1:0] den_top;

   cau_pkg::sat_type          sat_re, sat_im;
   logic                      rsp_valid_ff;
   logic signed [cau_pkg::DATA_W-1:0] res_real_ff, res_imag_ff, res_real_in, res_imag_in;
   logic                      overflow_ff, overflow_in, div_zero_ff, div_zero_in;

   // whole pipeline moves when the output register frees up
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   cau_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_valid),
      .mode     (req_mode),
      .a_real   (req_a_real),
      .a_imag   (req_a_imag),
      .b_real   (req_b_real),
      .b_imag   (req_b_imag),
      .mult_out (mult_out)
   );

   // divide setup: sign and magnitude, numerator scaled, divisor aligned
   always_comb begin
      neg_re    = mult_out.num_re[cau_pkg::SUM_W-1];
      neg_im    = mult_out.num_im[cau_pkg::SUM_W-1];
      abs_re    = neg_re ? cau_pkg::SUM_W'(-mult_out.num_re) : mult_out.num_re;
      abs_im    = neg_im ? cau_pkg::SUM_W'(-mult_out.num_im) : mult_out.num_im;
      scaled_re = {abs_re[cau_pkg::MAG_W-1:0], {cau_pkg::FRAC_BITS{1'b0}}};
      scaled_im = {abs_im[cau_pkg::MAG_W-1:0], {cau_pkg::FRAC_BITS{1'b0}}};
      den_top   = cau_pkg::CMP_W'(mult_out.den) << cau_pkg::QUO_W;

      prep_in.valid     = mult_out.valid;
      prep_in.is_div    = mult_out.is_div;
      prep_in.dz        = (mult_out.den == '0);
      prep_in.neg_re    = neg_re;
      prep_in.neg_im    = neg_im;
      // quotient would need more than QUO_W bits
      prep_in.big_re    = cau_pkg::CMP_W'(scaled_re) >= den_top;
      prep_in.big_im    = cau_pkg::CMP_W'(scaled_im) >= den_top;
      prep_in.direct_re = mult_out.direct_re;
      prep_in.direct_im = mult_out.direct_im;
      prep_in.r_re      = scaled_re;
      prep_in.r_im      = scaled_im;
      prep_in.q_re      = '0;
      prep_in.q_im      = '0;
      prep_in.d         = cau_pkg::DIV_W'(mult_out.den) << (cau_pkg::QUO_W - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (adv) begin
         prep_ff <= prep_in;
      end
   end

   assign stage_pipe[0] = prep_ff;

   for (genvar i = 0; i < cau_pkg::QUO_W; i++) begin : g_div
      cau_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .up_pipe (stage_pipe[i]),
         .dn_pipe (stage_pipe[i+1])
      );
   end

   assign last = stage_pipe[cau_pkg::QUO_W];

   always_comb begin
      if (last.is_div) begin
         sat_re = cau_pkg::sat_quot(last.neg_re, last.big_re, last.q_re);
         sat_im = cau_pkg::sat_quot(last.neg_im, last.big_im, last.q_im);
      end else begin
         sat_re = cau_pkg::sat_direct(last.direct_re);
         sat_im = cau_pkg::sat_direct(last.direct_im);
      end
      if (last.is_div && last.dz) begin
         res_real_in = '0;
         res_imag_in = '0;
         overflow_in = 1'b0;
         div_zero_in = 1'b1;
      end else begin
         res_real_in = sat_re.val;
         res_imag_in = sat_im.val;
         overflow_in = sat_re.ovf || sat_im.ovf;
         div_zero_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last.valid;
         res_real_ff  <= res_real_in;
         res_imag_ff  <= res_imag_in;
         overflow_ff  <= overflow_in;
         div_zero_ff  <= div_zero_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_real = res_real_ff;
   assign rsp_res_imag = res_imag_ff;
   assign rsp_overflow = overflow_ff;
   assign rsp_div_zero = div_zero_ff;

   a_dz_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_res_real == '0 && rsp_res_imag == '0 && !rsp_overflow)
      else $error("divide by zero item carries a nonzero result or overflow");

   a_ovf_saturated : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_res_real == cau_pkg::Q_MAX || rsp_res_real == cau_pkg::Q_MIN ||
         rsp_res_imag == cau_pkg::Q_MAX || rsp_res_imag == cau_pkg::Q_MIN)
      else $error("overflow flagged without a saturated part");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !prep_ff.valid && !mult_out.valid)
      else $error("pipeline holds an item right after reset");

endmodule

`default_nettype wire
